// File: src/dual_lfo_logic_combiner_assert.svh
// Assertion macros shared by the dual LFO combiner modules.
// No dependencies; included by the modules that carry checks.
`ifndef DUAL_LFO_LOGIC_COMBINER_ASSERT_SVH
`define DUAL_LFO_LOGIC_COMBINER_ASSERT_SVH

// Check a consequent in the same cycle as its antecedent.
`define DLC_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dlc: same-cycle check failed");

// Check a consequent in the cycle after its antecedent.
`define DLC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dlc: next-cycle check failed");

`endif

// File: src/dlc_pkg.sv
// Shared types and constants of the dual LFO logic combiner.
// No dependencies; every other file but the assertion macro header imports it.
package dlc_pkg;

  localparam int unsigned PHASE_W    = 32;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned SHAPE_W    = 16;
  localparam int unsigned GAIN_W     = 24;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHAPE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INC_A = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INC_B = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 3'd4;

  // Combine modes; the fourth code behaves as off
  localparam logic [MODE_W-1:0] MODE_AND = 2'd0;
  localparam logic [MODE_W-1:0] MODE_OFF = 2'd1;
  localparam logic [MODE_W-1:0] MODE_OR  = 2'd2;

  localparam logic [PHASE_W-1:0] HALF_CYCLE    = 32'h8000_0000;
  localparam logic [PHASE_W-1:0] QUARTER_CYCLE = 32'h4000_0000;
  localparam logic [SHAPE_W-1:0] SHAPE_MAX     = 16'd32768;
  // floor(2^46 / 32767): quotient by 65534 via (x >> 1) * RECIP >> 46
  localparam logic [31:0]        RECIP         = 32'd2147549186;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [SHAPE_W-1:0] shape;
    logic [PHASE_W-1:0] inc_a;
    logic [PHASE_W-1:0] inc_b;
    logic [GAIN_W-1:0]  gain;
  } dlc_cfg_t;

  // One strobe per datapath step, driven by the controller
  typedef struct packed {
    logic capture;
    logic mul;
    logic wave;
    logic prod;
    logic quot;
    logic emit;
  } dlc_cmd_t;

  typedef struct packed {
    logic out_free;
  } dlc_stat_t;

endpackage

// File: src/dlc_in_if.sv
// Sample request channel: valid/ready plus the two peak levels.
// Depends on dlc_pkg.
interface dlc_in_if import dlc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] left_level;
  logic [SAMPLE_W-1:0] right_level;

  modport source (output valid, output left_level, output right_level, input ready);
  modport sink   (input valid, input left_level, input right_level, output ready);
endinterface

// File: src/dlc_out_if.sv
// Result channel: valid/ready plus the four signed Q1.15 waves.
// Depends on dlc_pkg.
interface dlc_out_if import dlc_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] combined;
  logic signed [SAMPLE_W-1:0] wave_a;
  logic signed [SAMPLE_W-1:0] wave_b;
  logic signed [SAMPLE_W-1:0] quadrature;

  modport source (output valid, output combined, output wave_a, output wave_b,
                  output quadrature, input ready);
  modport sink   (input valid, input combined, input wave_a, input wave_b,
                  input quadrature, output ready);
endinterface

// File: src/dlc_regs.sv
// Configuration register file of the dual LFO combiner.
// Depends on dlc_pkg.
module dlc_regs import dlc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output dlc_cfg_t              cfg
);

  // Write the addressed register; drop writes to unused indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode  <= MODE_OFF;
      cfg.shape <= '0;
      cfg.inc_a <= '0;
      cfg.inc_b <= '0;
      cfg.gain  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:  cfg.mode  <= cfg_data[MODE_W-1:0];
        REG_SHAPE: cfg.shape <= cfg_data[SHAPE_W-1:0];
        REG_INC_A: cfg.inc_a <= cfg_data[PHASE_W-1:0];
        REG_INC_B: cfg.inc_b <= cfg_data[PHASE_W-1:0];
        REG_GAIN:  cfg.gain  <= cfg_data[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// File: src/dlc_ctrl.sv
// Sequencer of the dual LFO combiner: steps each request through the datapath.
// Depends on dlc_pkg and the assertion macro header.
`include "dual_lfo_logic_combiner_assert.svh"

module dlc_ctrl import dlc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  dlc_stat_t stat,
  output dlc_cmd_t  cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_WAVE = 3'd2;
  localparam logic [2:0] ST_PROD = 3'd3;
  localparam logic [2:0] ST_QUOT = 3'd4;
  localparam logic [2:0] ST_EMIT = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == ST_IDLE);

  // Advance one datapath step per cycle; hold in emit until the output is free
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_WAVE;
      end
      ST_WAVE: begin
        cmd.wave   = 1'b1;
        state_next = ST_PROD;
      end
      ST_PROD: begin
        cmd.prod   = 1'b1;
        state_next = ST_QUOT;
      end
      ST_QUOT: begin
        cmd.quot   = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `DLC_ASSERT_NEXT(a_accept_starts, clk, rst, in_valid && in_ready, state == ST_MUL)
  `DLC_ASSERT_SAME(a_one_step, clk, rst, 1'b1, $onehot0(cmd))
  `DLC_ASSERT_NEXT(a_emit_waits, clk, rst, (state == ST_EMIT) && !stat.out_free, state == ST_EMIT)

endmodule

// File: src/dlc_dp.sv
// Datapath of the dual LFO combiner: phases, morph waves, combiner, output register.
// Depends on dlc_pkg, the result interface and the assertion macro header.
`include "dual_lfo_logic_combiner_assert.svh"

module dlc_dp import dlc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  dlc_cfg_t            cfg,
  input  logic [SAMPLE_W-1:0] left_level,
  input  logic [SAMPLE_W-1:0] right_level,
  input  dlc_cmd_t            cmd,
  output dlc_stat_t           stat,
  dlc_out_if.source           result
);

  localparam int unsigned LANES  = 3;
  localparam int unsigned LANE_A = 0;
  localparam int unsigned LANE_B = 1;
  localparam int unsigned LANE_Q = 2;

  // Triangle minus square at one phase, 18-bit signed
  function automatic logic signed [17:0] tri_minus_sq(input logic [PHASE_W-1:0] ph);
    logic [PHASE_W-1:0] ph_off;
    logic [47:0]        scaled;
    logic signed [17:0] tri_v;
    logic signed [17:0] sq_v;
    ph_off = ph[31] ? {1'b0, ph[30:0]} : (HALF_CYCLE - ph);
    scaled = {ph_off, 16'h0000} - {15'h0000, ph_off, 1'b0};
    tri_v  = $signed({1'b0, scaled[47:31]}) - 18'sd32767;
    sq_v   = ph[31] ? -18'sd32767 : 18'sd32767;
    return tri_v - sq_v;
  endfunction

  // Base step plus feedback, saturated at half a cycle
  function automatic logic [PHASE_W-1:0] sat_step(input logic [PHASE_W-1:0] base,
                                                  input logic [24:0]        fb);
    logic [PHASE_W:0] sum;
    sum = {1'b0, base} + {8'h00, fb};
    return (sum > {1'b0, HALF_CYCLE}) ? HALF_CYCLE : sum[PHASE_W-1:0];
  endfunction

  logic [PHASE_W-1:0]         phase_a;
  logic [PHASE_W-1:0]         phase_b;
  logic [PHASE_W-1:0]         lane_phase [LANES];
  logic [SAMPLE_W-1:0]        peak;
  logic [SHAPE_W-1:0]         shape_c;
  logic signed [17:0]         diff [LANES];
  logic                       neg [LANES];
  logic signed [31:0]         span [LANES];
  logic signed [SAMPLE_W-1:0] wave [LANES];
  logic signed [SAMPLE_W-1:0] wave_next [LANES];
  logic signed [34:0]         span_full [LANES];
  logic [39:0]                fb_prod;
  logic [PHASE_W-1:0]         inc_a;
  logic [PHASE_W-1:0]         inc_b;
  logic [16:0]                ua;
  logic [16:0]                ub;
  logic [33:0]                prod_full;
  logic [31:0]                prod_ab;
  logic [62:0]                recip_full;
  logic [15:0]                qe;
  logic [31:0]                rem;
  logic [16:0]                quot_fix;
  logic signed [17:0]         and_v;
  logic signed [17:0]         or_v;
  logic                       active;
  logic signed [SAMPLE_W-1:0] comb_next;
  logic                       out_valid;
  logic signed [SAMPLE_W-1:0] out_comb;
  logic signed [SAMPLE_W-1:0] out_a;
  logic signed [SAMPLE_W-1:0] out_b;
  logic signed [SAMPLE_W-1:0] out_q;

  assign lane_phase[LANE_A] = phase_a;
  assign lane_phase[LANE_B] = phase_b;
  assign lane_phase[LANE_Q] = phase_a + QUARTER_CYCLE;

  // Per-lane morph: span multiply, then square plus span truncated toward zero
  for (genvar i = 0; i < LANES; i++) begin : g_lane
    logic signed [31:0] span_adj;
    logic signed [16:0] span_q;
    logic signed [17:0] wave_sum;

    assign span_full[i] = diff[i] * $signed({1'b0, shape_c});
    assign span_adj     = span[i] + (span[i][31] ? 32'sd32767 : 32'sd0);
    assign span_q       = $signed(span_adj[31:15]);
    assign wave_sum     = $signed({span_q[16], span_q}) + (neg[i] ? -18'sd32767 : 18'sd32767);
    assign wave_next[i] = wave_sum[SAMPLE_W-1:0];

    always_ff @(posedge clk) begin
      if (cmd.capture) begin
        diff[i] <= tri_minus_sq(lane_phase[i]);
        neg[i]  <= lane_phase[i][31];
      end
      if (cmd.mul) begin
        span[i] <= span_full[i][31:0];
      end
      if (cmd.wave) begin
        wave[i] <= wave_next[i];
      end
    end
  end

  // Unipolar waves and their product
  assign ua         = {wave[LANE_A][15], wave[LANE_A]} + 17'd32767;
  assign ub         = {wave[LANE_B][15], wave[LANE_B]} + 17'd32767;
  assign prod_full  = ua * ub;
  assign recip_full = prod_ab[31:1] * RECIP;

  // Correct the reciprocal estimate by one where the remainder reaches the divisor
  assign rem      = {1'b0, prod_ab[31:1]} + {16'h0000, qe} - {1'b0, qe, 15'h0000};
  assign quot_fix = {1'b0, qe} + ((rem >= 32'd32767) ? 17'd1 : 17'd0);
  assign and_v    = $signed({1'b0, quot_fix}) - 18'sd32767;
  assign or_v     = $signed({1'b0, ua}) + $signed({1'b0, ub}) - $signed({1'b0, quot_fix})
                    - 18'sd32767;

  assign active = (cfg.mode == MODE_AND) || (cfg.mode == MODE_OR);

  always_comb begin
    case (cfg.mode)
      MODE_AND: comb_next = and_v[SAMPLE_W-1:0];
      MODE_OR:  comb_next = or_v[SAMPLE_W-1:0];
      default:  comb_next = '0;
    endcase
  end

  // Capture the request, then run the feedback step and combiner arithmetic
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      peak    <= (left_level > right_level) ? left_level : right_level;
      shape_c <= (cfg.shape > SHAPE_MAX) ? SHAPE_MAX : cfg.shape;
    end
    if (cmd.mul) begin
      fb_prod <= peak * cfg.gain;
    end
    if (cmd.wave) begin
      inc_a <= sat_step(cfg.inc_a, fb_prod[39:15]);
      inc_b <= sat_step(cfg.inc_b, fb_prod[39:15]);
    end
    if (cmd.prod) begin
      prod_ab <= prod_full[31:0];
    end
    if (cmd.quot) begin
      qe <= recip_full[61:46];
    end
  end

  // Advance both phases once the outputs of this tick are captured
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_a <= '0;
      phase_b <= '0;
    end else if (cmd.prod) begin
      phase_a <= phase_a + inc_a;
      phase_b <= phase_b + inc_b;
    end
  end

  // Output register: load on emit, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_comb <= comb_next;
      out_a    <= active ? wave[LANE_A] : '0;
      out_b    <= active ? wave[LANE_B] : '0;
      out_q    <= active ? wave[LANE_Q] : '0;
    end
  end

  assign stat.out_free     = !out_valid || result.ready;
  assign result.valid      = out_valid;
  assign result.combined   = out_comb;
  assign result.wave_a     = out_a;
  assign result.wave_b     = out_b;
  assign result.quadrature = out_q;

  `DLC_ASSERT_SAME(a_emit_free, clk, rst, cmd.emit, !result.valid || result.ready)
  `DLC_ASSERT_NEXT(a_phase_hold, clk, rst, !cmd.prod, $stable(phase_a) && $stable(phase_b))
  `DLC_ASSERT_NEXT(a_off_silent, clk, rst, cmd.emit && !active, (out_comb == 16'sd0) && (out_a == 16'sd0))

endmodule

// File: src/dual_lfo_logic_combiner.sv
// Dual phase-accumulator LFO with AND/OR logic combiner. Each sample request
// is accepted, then passes through a chain of five dependent datapath steps
// (morph span multiply and feedback multiply, wave and step assembly,
// unipolar product and phase advance, reciprocal multiply for the divide by
// 65534, correction and combine); the last step waits until the output is
// free. The result sits in an output register, so the next request is taken
// while an earlier result still waits on the sink. Outputs use the phases from
// before the request's own phase advance. Configuration is written through a
// plain write port and must only change while the block is idle.
// Depends on dlc_pkg, dlc_in_if, dlc_out_if, dlc_regs, dlc_ctrl and dlc_dp.
module dual_lfo_logic_combiner import dlc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  dlc_in_if.sink                sample,
  dlc_out_if.source             result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dlc_cfg_t  cfg;
  dlc_cmd_t  cmd;
  dlc_stat_t stat;

  dlc_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dlc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample.valid),
    .in_ready (sample.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dlc_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .left_level  (sample.left_level),
    .right_level (sample.right_level),
    .cmd         (cmd),
    .stat        (stat),
    .result      (result)
  );

endmodule
